[rtl/multilevel_queue_quota_scheduler_macros.svh]
// Assertion helpers used by the scheduler controller RTL (mlqs_ctrl).
`ifndef MULTILEVEL_QUEUE_QUOTA_SCHEDULER_MACROS_SVH
`define MULTILEVEL_QUEUE_QUOTA_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

`define MLQS_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mlqs assertion failed");

`define MLQS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlqs implication failed");

`define MLQS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlqs next-cycle check failed");

`else

`define MLQS_ASSERT(name, clk, rst, expr)

`define MLQS_ASSERT_IMP(name, clk, rst, ante, cons)

`define MLQS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/mlqs_pkg.sv]
`default_nettype none

package mlqs_pkg;

   localparam int ID_W_PORT    = 8;
   localparam int LVL_W_PORT   = 3;
   localparam int LVL_PORT_MAX = 1 << LVL_W_PORT;

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/multilevel_queue_quota_scheduler.sv]
// Channel   Handshake             Fields                                             Dir
// request   req_valid/req_ready   mode, priority_req, process_id                     in
// response  rsp_valid/rsp_ready   got_valid, got_id, got_level, dropped, all_empty   out
//
// Each transfer passes capture, level decision with the id memory access,
// then result load; one request is in flight at a time.
// A new request is taken while the previous response still waits; a stalled
// response holds the load of the next one until it is taken.
// Synchronous reset empties every level FIFO and selects level 0 with a full
// quota; the id memory is not cleared.
`default_nettype none

module multilevel_queue_quota_scheduler
   import mlqs_pkg::*;
#(
   parameter int LEVELS     = 8,
   parameter int FIFO_DEPTH = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_mode,
   input  wire logic [LVL_W_PORT-1:0]   req_priority_req,
   input  wire logic [ID_W_PORT-1:0]    req_process_id,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_got_valid,
   output logic [ID_W_PORT-1:0]         rsp_got_id,
   output logic [LVL_W_PORT-1:0]        rsp_got_level,
   output logic                         rsp_dropped,
   output logic                         rsp_all_empty
);

   cmd_type cmd;

   mlqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mlqs_datapath #(
      .LEVELS     (LEVELS),
      .FIFO_DEPTH (FIFO_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_process_id   (req_process_id),
      .rsp_got_valid    (rsp_got_valid),
      .rsp_got_id       (rsp_got_id),
      .rsp_got_level    (rsp_got_level),
      .rsp_dropped      (rsp_dropped),
      .rsp_all_empty    (rsp_all_empty)
   );

endmodule

`default_nettype wire

[rtl/mlqs_ctrl.sv]
`default_nettype none

`include "multilevel_queue_quota_scheduler_macros.svh"

module mlqs_ctrl
   import mlqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = req_valid && req_ready;
      cmd.exec    = (state_ff == ST_EXEC);
      // result register is free, or is being emptied this cycle
      cmd.load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (cmd.load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   `MLQS_ASSERT_NXT(a_capture_to_exec, clock, reset, cmd.capture, state_ff == ST_EXEC)
   `MLQS_ASSERT_NXT(a_exec_to_done, clock, reset, state_ff == ST_EXEC, state_ff == ST_DONE)
   `MLQS_ASSERT_NXT(a_load_shows_result, clock, reset, cmd.load, rsp_valid_ff)
   `MLQS_ASSERT_NXT(a_done_waits_on_stall, clock, reset,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)

endmodule

`default_nettype wire

[rtl/mlqs_datapath.sv]
`default_nettype none

module mlqs_datapath
   import mlqs_pkg::*;
#(
   parameter int LEVELS     = 8,
   parameter int FIFO_DEPTH = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   input  wire logic                    req_mode,
   input  wire logic [LVL_W_PORT-1:0]   req_priority_req,
   input  wire logic [ID_W_PORT-1:0]    req_process_id,
   output logic                         rsp_got_valid,
   output logic [ID_W_PORT-1:0]         rsp_got_id,
   output logic [LVL_W_PORT-1:0]        rsp_got_level,
   output logic                         rsp_dropped,
   output logic                         rsp_all_empty
);

   // only levels the request field can address ever hold anything
   localparam int NL        = (LEVELS < LVL_PORT_MAX) ? LEVELS : LVL_PORT_MAX;
   localparam int LV_W      = $clog2(NL);
   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int SLOT_W    = $clog2(LEVELS + 1);
   localparam int STORE_W   = (ID_BITS < ID_W_PORT) ? ID_BITS : ID_W_PORT;
   localparam int MEM_DEPTH = NL * FIFO_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic [STORE_W-1:0] store_ff [MEM_DEPTH];
   logic [STORE_W-1:0] rdata_ff;

   logic                  mode_ff;
   logic [LVL_W_PORT-1:0] lvl_ff;
   logic [STORE_W-1:0]    id_ff;

   logic [PTR_W-1:0]  head_ff  [NL];
   logic [PTR_W-1:0]  head_in  [NL];
   logic [PTR_W-1:0]  tail_ff  [NL];
   logic [PTR_W-1:0]  tail_in  [NL];
   logic [CNT_W-1:0]  count_ff [NL];
   logic [CNT_W-1:0]  count_in [NL];
   logic [LV_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0] slots_ff, slots_in;

   logic              x_valid_ff, x_valid_in;
   logic [LV_W-1:0]   x_level_ff, x_level_in;
   logic              x_drop_ff, x_drop_in;

   logic                  rsp_got_valid_ff;
   logic [ID_W_PORT-1:0]  rsp_got_id_ff;
   logic [LVL_W_PORT-1:0] rsp_got_level_ff;
   logic                  rsp_dropped_ff;
   logic                  rsp_all_empty_ff;

   logic [NL-1:0]   nonempty;
   logic            any_nonempty;
   logic            hi_found, lo_found;
   logic [LV_W-1:0] hi_lvl, lo_lvl;
   logic            in_range, enq_ok;
   logic [LV_W-1:0] enq_lvl;
   logic [LV_W-1:0] pop_lvl;
   logic            mem_we, mem_re;
   logic [ADDR_W-1:0] waddr, raddr;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   assign any_nonempty = |nonempty;

   // descending scan: the last hit is the highest-priority candidate
   always_comb begin
      hi_found = 1'b0;
      hi_lvl   = '0;
      lo_found = 1'b0;
      lo_lvl   = '0;
      for (int i = NL - 1; i >= 0; i--) begin
         if (nonempty[i] && (LV_W'(i) < cur_ff)) begin
            hi_found = 1'b1;
            hi_lvl   = LV_W'(i);
         end
         if (nonempty[i] && (LV_W'(i) > cur_ff)) begin
            lo_found = 1'b1;
            lo_lvl   = LV_W'(i);
         end
      end
   end

   assign in_range = ({1'b0, lvl_ff} < (LVL_W_PORT + 1)'(NL));
   assign enq_lvl  = in_range ? lvl_ff[LV_W-1:0] : '0;
   assign enq_ok   = in_range && (count_ff[enq_lvl] != CNT_W'(FIFO_DEPTH));

   // level choice for a get; slots quota below preemption
   always_comb begin
      pop_lvl  = cur_ff;
      cur_in   = cur_ff;
      slots_in = slots_ff;
      priority if (hi_found) begin
         pop_lvl  = hi_lvl;
         cur_in   = hi_lvl;
         slots_in = SLOT_W'(LEVELS - 1) - SLOT_W'(hi_lvl);
      end else if (nonempty[cur_ff] && (slots_ff != '0)) begin
         slots_in = slots_ff - 1'b1;
      end else if (lo_found) begin
         pop_lvl  = lo_lvl;
         cur_in   = lo_lvl;
         slots_in = SLOT_W'(LEVELS - 1) - SLOT_W'(lo_lvl);
      end else begin
         // current level served anyway, quota left as is
         pop_lvl = cur_ff;
      end
   end

   assign waddr = ADDR_W'(enq_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(tail_ff[enq_lvl]);
   assign raddr = ADDR_W'(pop_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_ff[pop_lvl]);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      if (cmd.exec) begin
         if ((mode_ff == MODE_ENQ) && enq_ok) begin
            mem_we            = 1'b1;
            tail_in[enq_lvl]  = (tail_ff[enq_lvl] == PTR_W'(FIFO_DEPTH - 1)) ?
                                '0 : tail_ff[enq_lvl] + 1'b1;
            count_in[enq_lvl] = count_ff[enq_lvl] + 1'b1;
         end else if ((mode_ff == MODE_GET) && any_nonempty) begin
            mem_re            = 1'b1;
            head_in[pop_lvl]  = (head_ff[pop_lvl] == PTR_W'(FIFO_DEPTH - 1)) ?
                                '0 : head_ff[pop_lvl] + 1'b1;
            count_in[pop_lvl] = count_ff[pop_lvl] - 1'b1;
         end
      end
   end

   assign x_valid_in = (mode_ff == MODE_GET) && any_nonempty;
   assign x_level_in = x_valid_in ? pop_lvl : '0;
   assign x_drop_in  = (mode_ff == MODE_ENQ) && !enq_ok;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[waddr] <= id_ff;
      end
      if (mem_re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '{default: '0};
         tail_ff  <= '{default: '0};
         count_ff <= '{default: '0};
         cur_ff   <= '0;
         slots_ff <= SLOT_W'(LEVELS);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.exec && x_valid_in) begin
            cur_ff   <= cur_in;
            slots_ff <= slots_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         lvl_ff  <= req_priority_req;
         id_ff   <= req_process_id[STORE_W-1:0];
      end
      if (cmd.exec) begin
         x_valid_ff <= x_valid_in;
         x_level_ff <= x_level_in;
         x_drop_ff  <= x_drop_in;
      end
      // counts already hold this item's update when the result is loaded
      if (cmd.load) begin
         rsp_got_valid_ff <= x_valid_ff;
         rsp_got_id_ff    <= x_valid_ff ? ID_W_PORT'(rdata_ff) : '0;
         rsp_got_level_ff <= LVL_W_PORT'(x_level_ff);
         rsp_dropped_ff   <= x_drop_ff;
         rsp_all_empty_ff <= !any_nonempty;
      end
   end

   assign rsp_got_valid = rsp_got_valid_ff;
   assign rsp_got_id    = rsp_got_id_ff;
   assign rsp_got_level = rsp_got_level_ff;
   assign rsp_dropped   = rsp_dropped_ff;
   assign rsp_all_empty = rsp_all_empty_ff;

endmodule

`default_nettype wire

[test/multilevel_queue_quota_scheduler_checker.sv]
`default_nettype none

module multilevel_queue_quota_scheduler_checker
   import mlqs_pkg::*;
#(
   parameter int LEVELS     = 8,
   parameter int FIFO_DEPTH = 16,
   parameter int ID_BITS    = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_mode,
   input  wire logic [LVL_W_PORT-1:0] req_priority_req,
   input  wire logic [ID_W_PORT-1:0]  req_process_id,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  rsp_got_valid,
   input  wire logic [ID_W_PORT-1:0]  rsp_got_id,
   input  wire logic [LVL_W_PORT-1:0] rsp_got_level,
   input  wire logic                  rsp_dropped,
   input  wire logic                  rsp_all_empty,
   output int                         fail_count,
   output int                         outstanding
);

   localparam logic [ID_W_PORT-1:0] ID_MASK =
      (ID_BITS >= ID_W_PORT) ? '1 : ID_W_PORT'((1 << ID_BITS) - 1);

   typedef struct packed {
      logic                  got_valid;
      logic [ID_W_PORT-1:0]  got_id;
      logic [LVL_W_PORT-1:0] got_level;
      logic                  dropped;
      logic                  all_empty;
   } sched_result_type;

   logic [ID_W_PORT-1:0] id_store [LEVELS][FIFO_DEPTH];
   int unsigned          q_head  [LEVELS];
   int unsigned          q_tail  [LEVELS];
   int unsigned          q_count [LEVELS];
   int unsigned          cur_level;
   int unsigned          slots_left;

   sched_result_type     pending_results [$];
   int                   mismatch_total = 0;
   int                   rsp_index = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("mismatch at response %0d, %s: got %0h, expected %0h",
               rsp_index, field, seen, wanted);
      mismatch_total++;
   endtask

   function automatic bit any_queued();
      foreach (q_count[i])
         if (q_count[i] != 0)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [ID_W_PORT-1:0] take_head(input int unsigned lv);
      logic [ID_W_PORT-1:0] id;
      id = id_store[lv][q_head[lv]];
      q_head[lv] = (q_head[lv] + 1) % FIFO_DEPTH;
      q_count[lv]--;
      return id;
   endfunction

   function automatic sched_result_type schedule_item(input logic mode,
                                                      input logic [LVL_W_PORT-1:0] prio,
                                                      input logic [ID_W_PORT-1:0] pid);
      sched_result_type res;
      bit               found;
      res   = '0;
      found = 1'b0;
      if (cur_level >= LEVELS)
         cur_level = 0;
      if (mode == MODE_ENQ) begin
         // out-of-range level behaves like a full FIFO
         if (prio >= LEVELS || q_count[prio] >= FIFO_DEPTH) begin
            res.dropped = 1'b1;
         end else begin
            id_store[prio][q_tail[prio]] = pid & ID_MASK;
            q_tail[prio] = (q_tail[prio] + 1) % FIFO_DEPTH;
            q_count[prio]++;
         end
      end else if (any_queued()) begin
         for (int i = 0; i < int'(cur_level) && !found; i++) begin
            if (q_count[i] != 0) begin
               cur_level  = i;
               slots_left = LEVELS - i - 1;
               found      = 1'b1;
            end
         end
         if (found) begin
            res.got_valid = 1'b1;
         end else if (q_count[cur_level] != 0 && slots_left > 0) begin
            slots_left--;
            res.got_valid = 1'b1;
         end else begin
            // quota spent or current level empty: first nonempty lower level, else stay put
            for (int i = cur_level + 1; i < LEVELS && !found; i++) begin
               if (q_count[i] != 0) begin
                  cur_level  = i;
                  slots_left = LEVELS - i - 1;
                  found      = 1'b1;
               end
            end
            res.got_valid = found || q_count[cur_level] != 0;
         end
         if (res.got_valid) begin
            res.got_level = cur_level[LVL_W_PORT-1:0];
            res.got_id    = take_head(cur_level);
         end
      end
      res.all_empty = !any_queued();
      return res;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         foreach (q_count[i]) begin
            q_head[i]  = 0;
            q_tail[i]  = 0;
            q_count[i] = 0;
         end
         cur_level  = 0;
         slots_left = LEVELS;
         pending_results.delete();
      end else begin
         // response first, so a transfer never meets the request of the same edge
         if (rsp_valid && rsp_ready) begin
            rsp_index++;
            if (pending_results.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_got_id, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_got_valid !== want.got_valid)
                  report_mismatch("got_valid", rsp_got_valid, want.got_valid);
               if (rsp_got_id !== want.got_id)
                  report_mismatch("got_id", rsp_got_id, want.got_id);
               if (rsp_got_level !== want.got_level)
                  report_mismatch("got_level", rsp_got_level, want.got_level);
               if (rsp_dropped !== want.dropped)
                  report_mismatch("dropped", rsp_dropped, want.dropped);
               if (rsp_all_empty !== want.all_empty)
                  report_mismatch("all_empty", rsp_all_empty, want.all_empty);
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(schedule_item(req_mode, req_priority_req,
                                                    req_process_id));
      end
      fail_count  <= mismatch_total;
      outstanding <= pending_results.size();
   end

endmodule

`default_nettype wire

[test/multilevel_queue_quota_scheduler_tb.sv]
`default_nettype none

module multilevel_queue_quota_scheduler_tb;
   import mlqs_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int ITEM_TARGET      = 1900;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 150;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_mode         = MODE_ENQ;
   logic [LVL_W_PORT-1:0] req_priority_req = '0;
   logic [ID_W_PORT-1:0]  req_process_id   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_got_valid;
   logic [ID_W_PORT-1:0]  rsp_got_id;
   logic [LVL_W_PORT-1:0] rsp_got_level;
   logic                  rsp_dropped;
   logic                  rsp_all_empty;

   int                    fail_count;
   int                    outstanding;
   int unsigned           gap_limit     = 3;
   int unsigned           requests_sent = 0;

   multilevel_queue_quota_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_process_id   (req_process_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_got_valid    (rsp_got_valid),
      .rsp_got_id       (rsp_got_id),
      .rsp_got_level    (rsp_got_level),
      .rsp_dropped      (rsp_dropped),
      .rsp_all_empty    (rsp_all_empty)
   );

   multilevel_queue_quota_scheduler_checker sched_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_process_id   (req_process_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_got_valid    (rsp_got_valid),
      .rsp_got_id       (rsp_got_id),
      .rsp_got_level    (rsp_got_level),
      .rsp_dropped      (rsp_dropped),
      .rsp_all_empty    (rsp_all_empty),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // valid stays high across back-to-back transfers; lowered only for a gap
   task automatic offer_request(input logic mode, input logic [LVL_W_PORT-1:0] prio,
                                input logic [ID_W_PORT-1:0] pid);
      int unsigned gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_priority_req <= prio;
      req_process_id   <= pid;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   initial begin : response_side
      int unsigned stall;
      int unsigned stall_limit;
      int unsigned taken;
      stall_limit = 3;
      taken       = 0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 64 == 0)
            stall_limit = ($urandom_range(0, 3) == 0) ? 0 : 3;
         // one long hold-off lets the block back up onto its input
         stall = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : $urandom_range(0, stall_limit);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : request_side
      int unsigned           enq_pct;
      int unsigned           lo;
      int unsigned           phase_len;
      bit                    narrow;
      logic                  mode;
      logic [LVL_W_PORT-1:0] prio;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty get, extreme ids and levels, preemption, lower
      // takeover, quota spent with nothing below
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_ENQ, 3'd7, 8'h00);
      offer_request(MODE_ENQ, 3'd0, 8'hFF);
      offer_request(MODE_ENQ, 3'd3, 8'hA5);
      offer_request(MODE_ENQ, 3'd3, 8'h5A);
      offer_request(MODE_ENQ, 3'd5, 8'h01);
      offer_request(MODE_ENQ, 3'd6, 8'h80);
      offer_request(MODE_GET, 3'd7, 8'hFF);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_ENQ, 3'd1, 8'h7F);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_ENQ, 3'd7, 8'hFE);
      offer_request(MODE_ENQ, 3'd7, 8'h33);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);
      offer_request(MODE_GET, 3'd0, 8'h00);

      // overfill one level so the drop path is taken early
      lo = $urandom_range(0, 7);
      repeat (20) offer_request(MODE_ENQ, lo[LVL_W_PORT-1:0],
                                ID_W_PORT'($urandom_range(0, 255)));

      while (requests_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0:       enq_pct = 20;
            1:       enq_pct = 50;
            default: enq_pct = 80;
         endcase
         narrow    = $urandom_range(0, 1);
         lo        = $urandom_range(0, 6);
         phase_len = $urandom_range(40, 120);
         gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 3;
         repeat (phase_len) begin
            mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_GET;
            prio = narrow ? LVL_W_PORT'($urandom_range(lo, lo + 1))
                          : LVL_W_PORT'($urandom_range(0, 7));
            offer_request(mode, prio, ID_W_PORT'($urandom_range(0, 255)));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
